>>> rtl/core/itpa_pkg.sv
// Package for the integer to padded ASCII formatter.
// Holds mode codes, sequencer states, field width, character constants, digit limits and divide constants.
// No dependencies; used by integer_to_padded_ascii.
package itpa_pkg;

   // Formatting modes carried in the request tuser.
   typedef enum logic [1:0] {
      MODE_UDEC = 2'd0,
      MODE_HEX  = 2'd1,
      MODE_SDEC = 2'd2,
      MODE_PTR  = 2'd3
   } mode_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SETUP,
      ST_EMIT
   } state_type;

   // Default for the largest field width (the MAX_WIDTH parameter).
   localparam int MAX_WIDTH_DEFAULT = 64;

   // Digit buffer: a 32-bit value has at most ten decimal digits.
   localparam int DIG_MAX = 10;
   localparam int DIG_W   = 4;

   // Reciprocal of ten: x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // ASCII characters.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

endpackage

>>> rtl/core/integer_to_padded_ascii.sv
// Digits are extracted in a multiply state and a divide state per decimal digit, or in a
// divide state alone per hex digit; a setup state follows, then one character per cycle
// while rsp_tready does not stall the output.
// The divide-by-ten unit (reciprocal multiply, then remainder) sets the decimal digit rate.
// One item at a time: req_tready is high only while the sequencer is idle.
// Reset is synchronous and active high; it clears the sequencer and the output valid.
module integer_to_padded_ascii #(
   parameter int MAX_WIDTH = itpa_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // value[31:0], left_justify[32], zero_fill[33],
                                    // field_width[40:34], zeros[47:41]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // Response beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_out[7:0]
   output logic        rsp_tlast    // last_char
);

   localparam logic [6:0] WIDTH_CAP = 7'(MAX_WIDTH);

   // Request fields
   logic [31:0]        req_value;
   logic               req_ljust;
   logic               req_zfill;
   logic [6:0]         req_width;
   itpa_pkg::mode_type req_mode;

   assign req_value = req_tdata[31:0];
   assign req_ljust = req_tdata[32];
   assign req_zfill = req_tdata[33];
   assign req_width = req_tdata[40:34];
   assign req_mode  = itpa_pkg::mode_type'(req_tuser);

   // Registers
   itpa_pkg::state_type state_ff, state_in;
   logic [31:0] mag_ff, mag_in;
   logic [63:0] prod_ff;
   logic        neg_ff, neg_in;
   logic        hex_ff, hex_in;
   logic        ptr_ff, ptr_in;
   logic        ljust_ff, ljust_in;
   logic        zfill_ff, zfill_in;
   logic [6:0]  width_ff, width_in;
   logic [itpa_pkg::DIG_W-1:0] ndig_ff, ndig_in;
   logic [itpa_pkg::DIG_W-1:0] didx_ff, didx_in;
   logic [itpa_pkg::DIG_W-1:0] dig_ff [itpa_pkg::DIG_MAX];
   logic [6:0]  b1_ff, b1_in;
   logic [6:0]  b2_ff, b2_in;
   logic [6:0]  b3_ff, b3_in;
   logic [6:0]  b4_ff, b4_in;
   logic [6:0]  total_ff, total_in;
   logic [6:0]  pos_ff, pos_in;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_last_ff;

   // Control
   logic       accept;
   logic       out_load;
   logic       dig_write;
   logic       digit_last;
   logic [7:0] char_cur;
   logic       last_cur;

   // Divide step: quotient from the registered product, remainder as mag - 10 * quotient.
   logic [28:0] quot;
   logic [3:0]  q10_lo;
   logic [3:0]  digit_val;

   assign quot      = prod_ff[63:itpa_pkg::RECIP_SHIFT];
   assign q10_lo    = {quot[0], 3'b000} + {quot[2:0], 1'b0};
   assign digit_val = hex_ff ? mag_ff[3:0] : (mag_ff[3:0] - q10_lo);
   assign digit_last = hex_ff ? (mag_ff[31:4] == 28'd0) : (quot == 29'd0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itpa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_mode == itpa_pkg::MODE_HEX || req_mode == itpa_pkg::MODE_PTR) begin
                  state_in = itpa_pkg::ST_DIV;
               end else begin
                  state_in = itpa_pkg::ST_MUL;
               end
            end
         end
         itpa_pkg::ST_MUL: begin
            state_in = itpa_pkg::ST_DIV;
         end
         itpa_pkg::ST_DIV: begin
            if (digit_last) begin
               state_in = itpa_pkg::ST_SETUP;
            end else if (hex_ff) begin
               state_in = itpa_pkg::ST_DIV;
            end else begin
               state_in = itpa_pkg::ST_MUL;
            end
         end
         itpa_pkg::ST_SETUP: begin
            state_in = itpa_pkg::ST_EMIT;
         end
         itpa_pkg::ST_EMIT: begin
            if (out_load && last_cur) begin
               state_in = itpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itpa_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      dig_write  = 1'b0;
      unique case (state_ff)
         itpa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         itpa_pkg::ST_MUL: begin
         end
         itpa_pkg::ST_DIV: begin
            dig_write = 1'b1;
         end
         itpa_pkg::ST_SETUP: begin
         end
         itpa_pkg::ST_EMIT: begin
            out_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Character at the current position of the padded text.
   always_comb begin
      logic [3:0] d;
      d = dig_ff[didx_ff];
      if (pos_ff < b1_ff) begin
         char_cur = itpa_pkg::CHAR_SPACE;
      end else if (pos_ff < b2_ff) begin
         if (pos_ff == b1_ff) begin
            char_cur = neg_ff ? itpa_pkg::CHAR_MINUS : itpa_pkg::CHAR_ZERO;
         end else begin
            char_cur = itpa_pkg::CHAR_X;
         end
      end else if (pos_ff < b3_ff) begin
         char_cur = itpa_pkg::CHAR_ZERO;
      end else if (pos_ff < b4_ff) begin
         if (d < 4'd10) begin
            char_cur = itpa_pkg::CHAR_ZERO + {4'd0, d};
         end else begin
            char_cur = itpa_pkg::CHAR_A + {4'd0, d - 4'd10};
         end
      end else begin
         char_cur = itpa_pkg::CHAR_SPACE;
      end
   end

   assign last_cur = (pos_ff == total_ff - 7'd1);

   // Datapath next values
   always_comb begin
      logic [6:0] npre;
      logic [6:0] textlen;
      logic [6:0] pad;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      hex_in   = hex_ff;
      ptr_in   = ptr_ff;
      ljust_in = ljust_ff;
      zfill_in = zfill_ff;
      width_in = width_ff;
      ndig_in  = ndig_ff;
      didx_in  = didx_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      b3_in    = b3_ff;
      b4_in    = b4_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      npre     = neg_ff ? 7'd1 : (ptr_ff ? 7'd2 : 7'd0);
      textlen  = npre + {3'd0, ndig_ff};
      pad      = (width_ff > textlen) ? (width_ff - textlen) : 7'd0;

      // Capture the item; signed mode works on the magnitude.
      if (accept) begin
         neg_in   = (req_mode == itpa_pkg::MODE_SDEC) && req_value[31];
         mag_in   = neg_in ? (32'd0 - req_value) : req_value;
         hex_in   = (req_mode == itpa_pkg::MODE_HEX) || (req_mode == itpa_pkg::MODE_PTR);
         ptr_in   = (req_mode == itpa_pkg::MODE_PTR);
         ljust_in = req_ljust;
         zfill_in = req_zfill;
         width_in = (req_width > WIDTH_CAP) ? WIDTH_CAP : req_width;
         ndig_in  = '0;
      end

      // One digit per divide step, least significant first.
      if (dig_write) begin
         mag_in  = hex_ff ? {4'd0, mag_ff[31:4]} : {3'd0, quot};
         ndig_in = ndig_ff + 4'd1;
      end

      // Segment boundaries of the padded text.
      if (state_ff == itpa_pkg::ST_SETUP) begin
         b1_in    = (!ljust_ff && !zfill_ff) ? pad : 7'd0;
         b2_in    = b1_in + npre;
         b3_in    = b2_in + ((!ljust_ff && zfill_ff) ? pad : 7'd0);
         b4_in    = b3_in + {3'd0, ndig_ff};
         total_in = b4_in + (ljust_ff ? pad : 7'd0);
         pos_in   = 7'd0;
         didx_in  = ndig_ff - 4'd1;
      end

      // Walk the text one character per output beat.
      if (out_load) begin
         pos_in = pos_ff + 7'd1;
         if (pos_ff >= b3_ff && pos_ff < b4_ff && didx_ff != '0) begin
            didx_in = didx_ff - 4'd1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itpa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      prod_ff  <= {32'd0, mag_ff} * {32'd0, itpa_pkg::RECIP_TEN};
      neg_ff   <= neg_in;
      hex_ff   <= hex_in;
      ptr_ff   <= ptr_in;
      ljust_ff <= ljust_in;
      zfill_ff <= zfill_in;
      width_ff <= width_in;
      ndig_ff  <= ndig_in;
      didx_ff  <= didx_in;
      b1_ff    <= b1_in;
      b2_ff    <= b2_in;
      b3_ff    <= b3_in;
      b4_ff    <= b4_in;
      total_ff <= total_in;
      pos_ff   <= pos_in;
      if (out_load) begin
         rsp_data_ff <= char_cur;
         rsp_last_ff <= last_cur;
      end
   end

   // Digit buffer
   always_ff @(posedge clock) begin
      if (dig_write) begin
         dig_ff[ndig_ff] <= digit_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An accepted item blocks the request side on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while the previous item is in progress");

   // Emission never runs past the end of the text.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itpa_pkg::ST_EMIT) |-> (pos_ff < total_ff))
      else $error("character position beyond the text length");

   // The digit buffer never overflows.
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      dig_write |-> (ndig_ff < 4'(itpa_pkg::DIG_MAX)))
      else $error("digit buffer overflow");

   // The final character returns the sequencer to idle and is marked last.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_cur) |=> (state_ff == itpa_pkg::ST_IDLE) && rsp_tlast)
      else $error("last character did not end the item");

endmodule
